FILE: hw/rtl/fpts_pkg.sv
// Shared constants and types of the fixed-point Taylor sine pipeline.
package fpts_pkg;

	// Q16.16 angle constants
	localparam logic [19:0] TWO_PI_Q16    = 20'd411774;
	localparam logic [19:0] PI_Q16        = 20'd205887;

	// Taylor coefficients in Q16.16
	localparam logic [13:0] SIXTH_Q16     = 14'd10923;
	localparam logic [9:0]  ONE_120TH_Q16 = 10'd546;

	localparam logic [15:0] OUT_MAX       = 16'hFFFF;

	// Reciprocal of TWO_PI_Q16 scaled by 2**RECIP_SHIFT, rounded down
	localparam int          RECIP_SHIFT   = 50;
	localparam logic [31:0] RECIP_TWO_PI  = 32'((64'd1 << RECIP_SHIFT) / 64'd411774);
	localparam int          QUOT_W        = 64 - RECIP_SHIFT;

	// Width of a reduced angle in the first half period
	localparam int          PHASE_W       = 18;

	typedef struct packed {
		logic               mirror;
		logic [PHASE_W-1:0] a;
	} phase_t;

endpackage

FILE: hw/rtl/fixed_point_taylor_sine.sv
// Top level of the fixed-point Taylor sine: range reduction followed by the polynomial.
//
// Usage:
//   Input channel (angle_valid / angle_stall / angle) carries one unsigned
//   Q16.16 angle in radians per beat; any 32-bit value is legal.
//   Output channel (sine_valid / sine_stall / sine_value) carries one 16-bit
//   result per beat, in the same order as the angles came in.
//   A beat moves on a rising edge where valid is high and stall is low.
//
// Timing:
//   Eight register stages: three for the modulo-two-pi reduction (reciprocal
//   multiply, quotient multiply-subtract, correct and fold at pi) and five
//   for the polynomial (square, cube, fifth power with x^3/6, x^5/120, sum
//   with clamp and mirror). Each stage is at most one multiply deep; the
//   fifth-power stage runs its two products side by side.
//   Throughput is one beat per clock while the receiver does not stall.
//
// Reset and stall:
//   arst_n clears all stage valid bits; the datapath registers are not reset.
//   When the receiver stalls, the output register holds its beat, stages
//   behind it keep filling their bubbles, and angle_stall rises only once
//   every stage is occupied. Nothing is dropped or repeated.
module fixed_point_taylor_sine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        angle_valid,
	output logic        angle_stall,
	input  logic [31:0] angle,
	output logic        sine_valid,
	input  logic        sine_stall,
	output logic [15:0] sine_value
);

	logic             phase_valid;
	logic             phase_stall;
	fpts_pkg::phase_t phase;

	// reduce the angle to [0, pi) and flag the second half period
	fpts_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (angle_valid),
		.angle     (angle),
		.in_stall  (angle_stall),
		.out_valid (phase_valid),
		.out_phase (phase),
		.out_stall (phase_stall)
	);

	// evaluate, clamp and mirror
	fpts_poly u_poly (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (phase_valid),
		.in_phase   (phase),
		.in_stall   (phase_stall),
		.out_valid  (sine_valid),
		.sine_value (sine_value),
		.out_stall  (sine_stall)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		angle_stall |-> (sine_valid && sine_stall))
		else $error("input stalled while the output side can move");

endmodule

FILE: hw/rtl/fpts_reduce.sv
// Range reduction: angle modulo two pi, then fold into the first half period.
module fpts_reduce (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [31:0]      angle,
	output logic             in_stall,
	output logic             out_valid,
	output fpts_pkg::phase_t out_phase,
	input  logic             out_stall
);

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	logic [fpts_pkg::QUOT_W-1:0] q_s1;
	logic [31:0]                 angle_s1;
	logic [19:0]                 rem_s2;
	fpts_pkg::phase_t            phase_s3;

	logic [63:0] recip_prod;
	logic [31:0] quot_mul;
	logic [31:0] rem_full;
	logic [19:0] rem_fix;
	fpts_pkg::phase_t phase_nxt;

	// a stage advances when it is empty or the next one advances
	assign en_s3    = !v_s3 || !out_stall;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	// quotient estimate, equal to the true quotient or one below it
	assign recip_prod = {32'd0, angle} * {32'd0, fpts_pkg::RECIP_TWO_PI};

	assign quot_mul = 32'(q_s1) * 32'(fpts_pkg::TWO_PI_Q16);
	assign rem_full = angle_s1 - quot_mul;

	always_comb begin
		if (rem_s2 >= fpts_pkg::TWO_PI_Q16) begin
			rem_fix = rem_s2 - fpts_pkg::TWO_PI_Q16;
		end else begin
			rem_fix = rem_s2;
		end
		if (rem_fix >= fpts_pkg::PI_Q16) begin
			phase_nxt.mirror = 1'b1;
			phase_nxt.a      = fpts_pkg::PHASE_W'(rem_fix - fpts_pkg::PI_Q16);
		end else begin
			phase_nxt.mirror = 1'b0;
			phase_nxt.a      = fpts_pkg::PHASE_W'(rem_fix);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			q_s1     <= recip_prod[63:fpts_pkg::RECIP_SHIFT];
			angle_s1 <= angle;
		end
		if (en_s2 && v_s1) begin
			rem_s2 <= rem_full[19:0];
		end
		if (en_s3 && v_s2) begin
			phase_s3 <= phase_nxt;
		end
	end

	assign out_valid = v_s3;
	assign out_phase = phase_s3;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (rem_s2 < 20'(2 * 411774)))
		else $error("remainder estimate off by more than one period");

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (20'(phase_s3.a) < fpts_pkg::PI_Q16))
		else $error("folded angle not below pi");

endmodule

FILE: hw/rtl/fpts_poly.sv
// Taylor polynomial x - x^3/6 + x^5/120, clamp and mirror, one multiply deep per stage.
module fpts_poly (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  fpts_pkg::phase_t in_phase,
	output logic             in_stall,
	output logic             out_valid,
	output logic [15:0]      sine_value,
	input  logic             out_stall
);

	localparam int AW = fpts_pkg::PHASE_W;

	logic v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en_s4, en_s5, en_s6, en_s7, en_s8;

	logic [AW-1:0] a_s4, a_s5, a_s6, a_s7;
	logic          mirror_s4, mirror_s5, mirror_s6, mirror_s7;
	logic [19:0]   sq_s4, sq_s5;
	logic [21:0]   cube_s5;
	logic [25:0]   fifth_s6;
	logic [19:0]   term3_s6, term3_s7;
	logic [19:0]   term5_s7;
	logic [15:0]   sine_s8;

	logic [35:0] sq_full;
	logic [37:0] cube_full;
	logic [41:0] fifth_full;
	logic [35:0] term3_full;
	logic [35:0] term5_full;
	logic signed [21:0] sum;
	logic [15:0] mag;
	logic [15:0] sine_nxt;

	assign en_s8    = !v_s8 || !out_stall;
	assign en_s7    = !v_s7 || en_s8;
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign in_stall = !en_s4;

	assign sq_full    = 36'(in_phase.a) * 36'(in_phase.a);
	assign cube_full  = 38'(sq_s4) * 38'(a_s4);
	assign fifth_full = 42'(cube_s5) * 42'(sq_s5);
	assign term3_full = 36'(cube_s5) * 36'(fpts_pkg::SIXTH_Q16);
	assign term5_full = 36'(fifth_s6) * 36'(fpts_pkg::ONE_120TH_Q16);

	always_comb begin
		sum = $signed({4'd0, a_s7}) - $signed({2'd0, term3_s7}) + $signed({2'd0, term5_s7});
		if (sum[21]) begin
			mag = 16'd0;
		end else if (sum > $signed(22'(fpts_pkg::OUT_MAX))) begin
			mag = fpts_pkg::OUT_MAX;
		end else begin
			mag = sum[15:0];
		end
		sine_nxt = mirror_s7 ? (fpts_pkg::OUT_MAX - mag) : mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s4) begin
				v_s4 <= in_valid;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
			if (en_s6) begin
				v_s6 <= v_s5;
			end
			if (en_s7) begin
				v_s7 <= v_s6;
			end
			if (en_s8) begin
				v_s8 <= v_s7;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && in_valid) begin
			sq_s4     <= sq_full[35:16];
			a_s4      <= in_phase.a;
			mirror_s4 <= in_phase.mirror;
		end
		if (en_s5 && v_s4) begin
			cube_s5   <= cube_full[37:16];
			sq_s5     <= sq_s4;
			a_s5      <= a_s4;
			mirror_s5 <= mirror_s4;
		end
		if (en_s6 && v_s5) begin
			fifth_s6  <= fifth_full[41:16];
			term3_s6  <= term3_full[35:16];
			a_s6      <= a_s5;
			mirror_s6 <= mirror_s5;
		end
		if (en_s7 && v_s6) begin
			term5_s7  <= term5_full[35:16];
			term3_s7  <= term3_s6;
			a_s7      <= a_s6;
			mirror_s7 <= mirror_s6;
		end
		if (en_s8 && v_s7) begin
			sine_s8 <= sine_nxt;
		end
	end

	assign out_valid  = v_s8;
	assign sine_value = sine_s8;

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s8 |-> !in_stall)
		else $error("polynomial pipeline stalls with an empty output register");

endmodule
